// File: sv/mts_pkg.sv
package mts_pkg;

  // Default configuration of the player.
  localparam int unsigned SongCountDef    = 7;
  localparam int unsigned NoteRomDepthDef = 32;

  // Number of songs held in the note table.
  localparam int unsigned BuiltinSongs = 6;

  // Timer clock and the resulting tone periods, rounded down.
  localparam int unsigned TimerHz = 1000000;
  localparam logic [15:0] PerC4 = 16'(TimerHz / 262);
  localparam logic [15:0] PerD4 = 16'(TimerHz / 294);
  localparam logic [15:0] PerE4 = 16'(TimerHz / 330);
  localparam logic [15:0] PerG4 = 16'(TimerHz / 392);
  localparam logic [15:0] PerA4 = 16'(TimerHz / 440);
  localparam logic [15:0] PerC5 = 16'(TimerHz / 523);
  localparam logic [15:0] PerE5 = 16'(TimerHz / 659);
  localparam logic [15:0] PerG5 = 16'(TimerHz / 784);
  localparam logic [15:0] PerA5 = 16'(TimerHz / 880);

  // Command codes of the input word.
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAY = 2'd1,
    CMD_STOP = 2'd2
  } mts_cmd_e;

  // Input word.
  typedef struct packed {
    logic [1:0] command;
    logic [2:0] song_id;
  } mts_in_t;

  // Output word.
  typedef struct packed {
    logic [15:0] tone_period;
    logic [14:0] tone_compare;
    logic        playing;
  } mts_out_t;

  // One note table entry; a length of zero marks the end of a song.
  typedef struct packed {
    logic [15:0] period;
    logic [7:0]  length;
  } mts_note_t;

  // Note table. Entries past the last song read as end marks.
  function automatic mts_note_t note_rom_f(logic [4:0] idx);
    mts_note_t n;
    n = '0;
    case (idx)
      5'd0:  n = '{PerC4, 8'd1};
      5'd1:  n = '{PerE4, 8'd1};
      5'd2:  n = '{PerG4, 8'd1};
      5'd3:  n = '{PerC5, 8'd2};
      5'd5:  n = '{PerG4, 8'd1};
      5'd6:  n = '{PerC5, 8'd1};
      5'd8:  n = '{PerC5, 8'd1};
      5'd9:  n = '{PerE5, 8'd1};
      5'd10: n = '{PerG5, 8'd1};
      5'd12: n = '{PerG4, 8'd1};
      5'd13: n = '{PerE4, 8'd1};
      5'd14: n = '{PerC4, 8'd1};
      5'd16: n = '{PerA4, 8'd1};
      5'd17: n = '{16'd0, 8'd1};
      5'd18: n = '{PerA4, 8'd1};
      5'd19: n = '{16'd0, 8'd1};
      5'd20: n = '{PerA5, 8'd2};
      5'd22: n = '{PerE4, 8'd2};
      5'd23: n = '{PerD4, 8'd2};
      5'd24: n = '{PerC4, 8'd4};
      default: n = '0;
    endcase
    return n;
  endfunction

  // First table entry of each song.
  function automatic logic [4:0] song_start_f(logic [2:0] sid);
    logic [4:0] s;
    s = '0;
    case (sid)
      3'd2:    s = 5'd5;
      3'd3:    s = 5'd8;
      3'd4:    s = 5'd12;
      3'd5:    s = 5'd16;
      3'd6:    s = 5'd22;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

// File: sv/mts_player.sv
module mts_player #(
  parameter int unsigned SONG_COUNT     = mts_pkg::SongCountDef,
  parameter int unsigned NOTE_ROM_DEPTH = mts_pkg::NoteRomDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  mts_pkg::mts_in_t cmd_i,
  output mts_pkg::mts_out_t res_o
);
  import mts_pkg::*;

  logic        active_q,  active_d;
  logic [4:0]  ptr_q,     ptr_d;
  logic [7:0]  ticks_q,   ticks_d;
  logic [15:0] period_q,  period_d;

  logic [4:0]  start_tab [8];
  mts_note_t   note;
  logic [5:0]  ptr_inc;
  logic        ptr_wrap;
  logic        song_ok;

  // Song start points folded into the table depth at elaboration.
  for (genvar g = 0; g < 8; g++) begin : g_start
    localparam int unsigned StartMod = 32'(song_start_f(3'(g))) % NOTE_ROM_DEPTH;
    assign start_tab[g] = 5'(StartMod);
  end

  // Table read; an entry beyond the depth is an end mark.
  always_comb begin
    note = '0;
    if (32'(ptr_q) < NOTE_ROM_DEPTH) begin
      note = note_rom_f(ptr_q);
    end
  end

  // Pointer advance, wrapping at the table depth and at the pointer width.
  assign ptr_inc  = {1'b0, ptr_q} + 6'd1;
  assign ptr_wrap = (32'(ptr_inc) >= NOTE_ROM_DEPTH) || ptr_inc[5];

  assign song_ok = (cmd_i.song_id != 3'd0) && (32'(cmd_i.song_id) < SONG_COUNT) &&
                   (32'(cmd_i.song_id) <= BuiltinSongs);

  // Next state for one command word.
  always_comb begin
    active_d = active_q;
    ptr_d    = ptr_q;
    ticks_d  = ticks_q;
    period_d = period_q;
    case (cmd_i.command)
      CMD_PLAY: begin
        if (song_ok) begin
          active_d = 1'b1;
          ptr_d    = start_tab[cmd_i.song_id];
          ticks_d  = '0;
        end else begin
          active_d = 1'b0;
          ptr_d    = '0;
          ticks_d  = '0;
          period_d = '0;
        end
      end
      CMD_STOP: begin
        active_d = 1'b0;
        ptr_d    = '0;
        ticks_d  = '0;
        period_d = '0;
      end
      CMD_TICK: begin
        if (active_q) begin
          if (ticks_q != 8'd0) begin
            ticks_d = ticks_q - 8'd1;
          end else if (note.length == 8'd0) begin
            active_d = 1'b0;
            ptr_d    = '0;
            ticks_d  = '0;
            period_d = '0;
          end else begin
            period_d = note.period;
            ticks_d  = note.length - 8'd1;
            ptr_d    = ptr_wrap ? 5'd0 : ptr_inc[4:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // The result reports the state after the update.
  assign res_o.tone_period  = period_d;
  assign res_o.tone_compare = period_d[15:1];
  assign res_o.playing      = active_d;

  // Player state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ptr_q    <= '0;
      ticks_q  <= '0;
      period_q <= '0;
    end else if (en_i) begin
      active_q <= active_d;
      ptr_q    <= ptr_d;
      ticks_q  <= ticks_d;
      period_q <= period_d;
    end
  end

  // An idle player is always silent.
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (period_q == 16'd0))
    else $error("idle player holds a tone period");

  // A countdown only runs while a song is active.
  a_count_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ticks_q != 8'd0) |-> active_q)
    else $error("countdown running while idle");

  // The note pointer never leaves the table.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < NOTE_ROM_DEPTH)
    else $error("note pointer beyond table depth");

  // State holds when no word is processed.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable({active_q, ptr_q, ticks_q, period_q}))
    else $error("player state changed without a word");

endmodule

// File: sv/melody_tone_sequencer.sv
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid_i/in_stall_o   | mts_in_t  (command, song_id)
// out     | output    | out_valid_o/out_stall_i | mts_out_t (period, compare, playing)
//
// One word is accepted per cycle while in_stall_o is low; its result passes through
// the input register, then the player update into the output register.
// The player state is a single register set updated as a word moves to the output.
// Reset clears the player to idle and silent, and empties both registers.
// A stall on the output holds the output word; the input register keeps
// accepting until it too is full, so the input stalls one word later.
module melody_tone_sequencer #(
  parameter int unsigned SONG_COUNT     = mts_pkg::SongCountDef,
  parameter int unsigned NOTE_ROM_DEPTH = mts_pkg::NoteRomDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mts_pkg::mts_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mts_pkg::mts_out_t out_data_o
);
  import mts_pkg::*;

  logic     in_valid_q, in_valid_d;
  mts_in_t  in_word_q;
  logic     out_valid_q, out_valid_d;
  mts_out_t out_word_q;
  mts_out_t res;
  logic     out_free;
  logic     advance;
  logic     in_take;

  // The output register can load when empty or being emptied.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take || (in_valid_q && !out_free);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  // Player state and update logic.
  mts_player #(
    .SONG_COUNT     (SONG_COUNT),
    .NOTE_ROM_DEPTH (NOTE_ROM_DEPTH)
  ) u_player (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cmd_i  (in_word_q),
    .res_o  (res)
  );

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_data_i;
    end
    if (advance) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // A word held in the input register stays until it moves on.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_word_q)))
    else $error("input word lost while output stalled");

  // The output word only changes when a new word is loaded.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !advance) |=> $stable(out_word_q))
    else $error("output word changed without a load");

  // The input is never stalled while the output register has room.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_free |-> !in_stall_o)
    else $error("input stalled with output free");

endmodule
